/* hw/rtl/csvs_pkg.sv */
// ----------------------------------------------------------------------------
// csvs_pkg
// Shared types, byte codes and the per-byte field rule of the csv splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package csvs_pkg;

  // special byte values
  localparam logic [7:0] BYTE_NL = 8'h0A;
  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_QT = 8'h22;

  // configuration defaults and register indexes
  localparam logic [7:0] SEP_RESET       = 8'd44;
  localparam int         CFG_IDX_W       = 1;
  localparam int         CFG_DATA_W      = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER    = 1'd1;

  // parameter defaults
  localparam int HELD_CR_MAX_DEF = 15;
  localparam int MAX_FIELDS_DEF  = 256;

  // result kinds
  typedef enum logic [1:0] {
    KIND_DATA      = 2'd0,
    KIND_FIELD_END = 2'd1,
    KIND_ROW_END   = 2'd2
  } kind_t;

  // one input item
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } item_t;

  // one result item
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic [7:0] field_index;
    logic       is_header;
    logic [8:0] widest_row;
    logic       last;
  } result_t;

  // step status from the parser core to the pipeline control
  typedef struct packed {
    logic emit;
    logic done;
  } core_stat_t;

  // outcome of one line-content byte
  typedef struct packed {
    logic       emit;
    kind_t      kind;
    logic [7:0] data;
    logic       inc;
    logic       in_quotes;
    logic       pending;
  } take_t;

  // quote handling and separator detection for one line-content byte
  function automatic take_t take_byte(input logic [7:0] b, input logic [7:0] sep,
                                      input logic iq, input logic pend);
    take_t t;
    t.emit      = 1'b0;
    t.kind      = KIND_DATA;
    t.data      = 8'd0;
    t.inc       = 1'b0;
    t.in_quotes = iq;
    t.pending   = pend;
    if (b == BYTE_QT) begin
      if (pend) begin
        // doubled quote inside quotes gives a literal quote
        t.pending = 1'b0;
        t.emit    = 1'b1;
        t.data    = BYTE_QT;
      end else if (iq) begin
        t.pending = 1'b1;
      end else begin
        t.in_quotes = 1'b1;
      end
    end else begin
      // a lone quote followed by anything else closes the quotes
      if (pend) begin
        t.pending   = 1'b0;
        t.in_quotes = 1'b0;
      end
      t.emit = 1'b1;
      if (b == sep && !t.in_quotes) begin
        t.kind = KIND_FIELD_END;
        t.inc  = 1'b1;
      end else begin
        t.data = b;
      end
    end
    return t;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/csvs_in_stage.sv */
// ----------------------------------------------------------------------------
// csvs_in_stage
// Input register holding the byte under work; takes a new byte as the
// current one finishes.
// ----------------------------------------------------------------------------
`default_nettype none

module csvs_in_stage (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire csvs_pkg::item_t      in_item,
  input  wire logic                 out_room,
  input  wire csvs_pkg::core_stat_t stat,
  output csvs_pkg::item_t           work_item,
  output logic                      advance
);
  import csvs_pkg::*;

  logic  work_valid_r, work_valid_nxt;
  item_t work_r;
  logic  finish;
  logic  take;

  // a step runs whenever there is work and the result register has room
  assign advance   = work_valid_r && out_room;
  assign finish    = advance && stat.done;
  assign in_stall  = work_valid_r && !finish;
  assign take      = in_valid && !in_stall;
  assign work_item = work_r;

  // occupancy of the work register
  always_comb begin
    work_valid_nxt = work_valid_r;
    if (take) begin
      work_valid_nxt = 1'b1;
    end else if (finish) begin
      work_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_valid_r <= 1'b0;
    end else begin
      work_valid_r <= work_valid_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (take) begin
      work_r <= in_item;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/csvs_core.sv */
// ----------------------------------------------------------------------------
// csvs_core
// Parser state and one splitter step per cycle while the result register has
// room: stream end, row end, CR hold or release, or one line-content byte.
// ----------------------------------------------------------------------------
`default_nettype none

module csvs_core #(
  parameter int HELD_CR_MAX = csvs_pkg::HELD_CR_MAX_DEF,
  parameter int MAX_FIELDS  = csvs_pkg::MAX_FIELDS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire csvs_pkg::item_t item,
  input  wire logic            advance,
  input  wire logic [7:0]      sep,
  input  wire logic            hdr_en,
  output csvs_pkg::result_t    res,
  output csvs_pkg::core_stat_t stat
);
  import csvs_pkg::*;

  localparam int HW = $clog2(HELD_CR_MAX + 1);
  localparam int FW = $clog2(MAX_FIELDS);
  localparam int CW = $clog2(MAX_FIELDS + 1);
  localparam logic [HW-1:0] HELD_MAX = HW'(HELD_CR_MAX);
  localparam logic [FW-1:0] FP_MAX   = FW'(MAX_FIELDS - 1);

  logic          iq_r, iq_nxt;
  logic          pend_r, pend_nxt;
  logic [HW-1:0] held_r, held_nxt;
  logic [FW-1:0] fp_r, fp_nxt;
  logic [CW-1:0] max_r, max_nxt;
  logic          first_r, first_nxt;
  logic          line_r, line_nxt;

  logic [CW-1:0] count;
  logic [CW-1:0] max_upd;
  logic [FW-1:0] fp_inc;
  take_t         tk_cr;
  take_t         tk_q;
  take_t         tk_b;
  logic          emit;
  logic          done;
  logic          last;
  kind_t         kind;
  logic [7:0]    data;

  // field count of the current row and the running widest row
  assign count   = CW'(fp_r) + CW'(1);
  assign max_upd = (count > max_r) ? count : max_r;
  assign fp_inc  = (fp_r == FP_MAX) ? fp_r : fp_r + FW'(1);

  // a released carriage return never sees a pending quote
  assign tk_cr = take_byte(BYTE_CR, sep, iq_r & ~pend_r, 1'b0);
  assign tk_q  = take_byte(BYTE_QT, sep, tk_cr.in_quotes, tk_cr.pending);
  assign tk_b  = take_byte(item.in_byte, sep, iq_r, pend_r);

  // step decision and next state
  always_comb begin
    iq_nxt    = iq_r;
    pend_nxt  = pend_r;
    held_nxt  = held_r;
    fp_nxt    = fp_r;
    max_nxt   = max_r;
    first_nxt = first_r;
    line_nxt  = line_r;
    emit      = 1'b0;
    done      = 1'b1;
    last      = 1'b1;
    kind      = KIND_DATA;
    data      = 8'd0;
    if (item.end_of_stream) begin
      // flush an open line, then back to the reset state
      emit      = line_r;
      kind      = KIND_ROW_END;
      iq_nxt    = 1'b0;
      pend_nxt  = 1'b0;
      held_nxt  = '0;
      fp_nxt    = '0;
      max_nxt   = '0;
      first_nxt = 1'b1;
      line_nxt  = 1'b0;
    end else if (item.in_byte == BYTE_NL) begin
      // newline ends the row, held carriage returns dropped
      emit      = 1'b1;
      kind      = KIND_ROW_END;
      max_nxt   = max_upd;
      iq_nxt    = 1'b0;
      pend_nxt  = 1'b0;
      held_nxt  = '0;
      fp_nxt    = '0;
      first_nxt = 1'b0;
      line_nxt  = 1'b0;
    end else if (item.in_byte == BYTE_CR) begin
      line_nxt = 1'b1;
      pend_nxt = 1'b0;
      if (held_r == HELD_MAX) begin
        // hold is full: oldest carriage return goes out as content
        emit    = 1'b1;
        kind    = tk_cr.kind;
        data    = tk_cr.data;
        max_nxt = max_upd;
        iq_nxt  = tk_cr.in_quotes;
        if (tk_cr.inc) begin
          fp_nxt = fp_inc;
        end
      end else begin
        iq_nxt   = iq_r & ~pend_r;
        held_nxt = held_r + HW'(1);
      end
    end else if (held_r != '0) begin
      // release one held carriage return ahead of the byte
      line_nxt = 1'b1;
      emit     = 1'b1;
      kind     = tk_cr.kind;
      data     = tk_cr.data;
      max_nxt  = max_upd;
      iq_nxt   = tk_cr.in_quotes;
      pend_nxt = tk_cr.pending;
      held_nxt = held_r - HW'(1);
      if (tk_cr.inc) begin
        fp_nxt = fp_inc;
      end
      if (held_r == HW'(1) && item.in_byte == BYTE_QT) begin
        // a trailing quote gives no result, fold it into this step
        iq_nxt   = tk_q.in_quotes;
        pend_nxt = tk_q.pending;
      end else begin
        done = 1'b0;
        last = 1'b0;
      end
    end else begin
      // ordinary line-content byte
      line_nxt = 1'b1;
      emit     = tk_b.emit;
      kind     = tk_b.kind;
      data     = tk_b.data;
      iq_nxt   = tk_b.in_quotes;
      pend_nxt = tk_b.pending;
      if (tk_b.emit) begin
        max_nxt = max_upd;
      end
      if (tk_b.inc) begin
        fp_nxt = fp_inc;
      end
    end
  end

  // result fields
  always_comb begin
    res.kind        = kind;
    res.data_byte   = data;
    res.field_index = 8'(fp_r);
    res.is_header   = first_r & hdr_en;
    res.widest_row  = 9'(max_upd);
    res.last        = last;
    stat.emit       = emit;
    stat.done       = done;
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iq_r    <= 1'b0;
      pend_r  <= 1'b0;
      held_r  <= '0;
      fp_r    <= '0;
      max_r   <= '0;
      first_r <= 1'b1;
      line_r  <= 1'b0;
    end else if (advance) begin
      iq_r    <= iq_nxt;
      pend_r  <= pend_nxt;
      held_r  <= held_nxt;
      fp_r    <= fp_nxt;
      max_r   <= max_nxt;
      first_r <= first_nxt;
      line_r  <= line_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/csvs_out_stage.sv */
// ----------------------------------------------------------------------------
// csvs_out_stage
// Result register between the parser core and the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module csvs_out_stage (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 advance,
  input  wire csvs_pkg::core_stat_t stat,
  input  wire csvs_pkg::result_t    res,
  output logic                      out_room,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output csvs_pkg::result_t         out_res
);
  import csvs_pkg::*;

  logic    out_valid_r, out_valid_nxt;
  result_t res_r;
  logic    load;

  // register frees up when empty or when its transfer completes
  assign out_room  = !out_valid_r || !out_stall;
  assign load      = advance && stat.emit;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_room) begin
      out_valid_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/csv_line_field_splitter.sv */
// ----------------------------------------------------------------------------
// csv_line_field_splitter
// Splits a byte stream into rows and fields with quote escape, carriage
// return stripping, header flag and widest-row tracking.
// ----------------------------------------------------------------------------
// Path: a byte goes through the input register, parser core and result register.
// Throughput: one byte per cycle when the result channel does not stall; a byte
//   behind held CRs waits for their release, one per step; a quote joins the last.
// Reset: synchronous, active low; clears the parser state and both handshakes
//   and sets the separator to a comma and the header flag to 0.
`default_nettype none

module csv_line_field_splitter #(
  parameter int HELD_CR_MAX = csvs_pkg::HELD_CR_MAX_DEF,
  parameter int MAX_FIELDS  = csvs_pkg::MAX_FIELDS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // configuration
  input  wire logic                                cfg_wr_en,
  input  wire logic [csvs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [csvs_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [7:0]                          in_byte,
  input  wire logic                                in_end_of_stream,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [1:0]                               out_kind,
  output logic [7:0]                               out_data_byte,
  output logic [7:0]                               out_field_index,
  output logic                                     out_is_header,
  output logic [8:0]                               out_widest_row,
  output logic                                     out_last
);
  import csvs_pkg::*;

  logic [7:0] sep_r;
  logic       hdr_r;
  item_t      in_item;
  item_t      work_item;
  logic       advance;
  logic       out_room;
  core_stat_t stat;
  result_t    res;
  result_t    out_res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r <= SEP_RESET;
      hdr_r <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SEPARATOR: sep_r <= cfg_data[7:0];
        CFG_HEADER:    hdr_r <= cfg_data[0];
        default:       ;
      endcase
    end
  end

  assign in_item.in_byte       = in_byte;
  assign in_item.end_of_stream = in_end_of_stream;

  // input register
  csvs_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_room  (out_room),
    .stat      (stat),
    .work_item (work_item),
    .advance   (advance)
  );

  // parser core
  csvs_core #(
    .HELD_CR_MAX (HELD_CR_MAX),
    .MAX_FIELDS  (MAX_FIELDS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .item    (work_item),
    .advance (advance),
    .sep     (sep_r),
    .hdr_en  (hdr_r),
    .res     (res),
    .stat    (stat)
  );

  // result register
  csvs_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .stat      (stat),
    .res       (res),
    .out_room  (out_room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_kind        = out_res.kind;
  assign out_data_byte   = out_res.data_byte;
  assign out_field_index = out_res.field_index;
  assign out_is_header   = out_res.is_header;
  assign out_widest_row  = out_res.widest_row;
  assign out_last        = out_res.last;

endmodule

`default_nettype wire

/* tb/sv/csv_splitter_checker.sv */
// ----------------------------------------------------------------------------
// csv_splitter_checker
// Watches the byte, result and register ports of the csv splitter. Keeps its
// own copy of the row/field parser state, predicts the result transfers caused
// by every accepted byte and compares each result transfer field by field with
// the oldest prediction. Hands the error count and the number of outstanding
// predictions to the testbench top.
// ----------------------------------------------------------------------------
module csv_splitter_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [csvs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [csvs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [7:0]                      in_byte,
  input  logic                            in_end_of_stream,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [1:0]                      out_kind,
  input  logic [7:0]                      out_data_byte,
  input  logic [7:0]                      out_field_index,
  input  logic                            out_is_header,
  input  logic [8:0]                      out_widest_row,
  input  logic                            out_last,
  output int                              fail_count,
  output int                              open_count
);
  import csvs_pkg::*;

  localparam int CR_HOLD_LIMIT = HELD_CR_MAX_DEF;
  localparam int LAST_FIELD    = MAX_FIELDS_DEF - 1;

  // register copies
  logic [7:0] sep_byte;
  logic       header_en;

  // parser state copy
  logic       quoted;
  logic       quote_seen;
  int         held_crs;
  logic [7:0] field_pos;
  logic [8:0] widest;
  logic       first_row;
  logic       line_open;

  // pending field predictions, oldest first
  result_t    field_events_q[$];
  int         step_events;

  // one predicted result at the current field position
  function automatic void push_event(kind_t k, logic [7:0] b);
    result_t    r;
    logic [8:0] count;
    count = {1'b0, field_pos} + 9'd1;
    if (count > widest) widest = count;
    r.kind        = k;
    r.data_byte   = b;
    r.field_index = field_pos;
    r.is_header   = first_row && header_en;
    r.widest_row  = widest;
    r.last        = 1'b0;
    field_events_q.push_back(r);
    step_events++;
  endfunction

  // one line content byte through quote and separator handling
  function automatic void line_byte(logic [7:0] b);
    if (b == BYTE_QT) begin
      if (quote_seen) begin
        quote_seen = 1'b0;
        push_event(KIND_DATA, BYTE_QT);
      end else if (quoted) begin
        quote_seen = 1'b1;
      end else begin
        quoted = 1'b1;
      end
    end else begin
      // a lone quote followed by anything else leaves quoted mode
      if (quote_seen) begin
        quote_seen = 1'b0;
        quoted     = 1'b0;
      end
      if (b == sep_byte && !quoted) begin
        push_event(KIND_FIELD_END, 8'd0);
        if (field_pos < LAST_FIELD) field_pos++;
      end else begin
        push_event(KIND_DATA, b);
      end
    end
  endfunction

  function automatic void close_row();
    push_event(KIND_ROW_END, 8'd0);
    quoted     = 1'b0;
    quote_seen = 1'b0;
    held_crs   = 0;
    field_pos  = 8'd0;
    first_row  = 1'b0;
    line_open  = 1'b0;
  endfunction

  function automatic void clear_stream();
    quoted     = 1'b0;
    quote_seen = 1'b0;
    held_crs   = 0;
    field_pos  = 8'd0;
    widest     = 9'd0;
    first_row  = 1'b1;
    line_open  = 1'b0;
  endfunction

  // predictions for one accepted byte transfer
  function automatic void predict_byte(logic [7:0] b, logic eos);
    result_t r;
    step_events = 0;
    if (eos) begin
      if (line_open) close_row();
      clear_stream();
    end else if (b == BYTE_NL) begin
      close_row();
    end else begin
      line_open = 1'b1;
      if (b == BYTE_CR) begin
        if (quote_seen) begin
          quote_seen = 1'b0;
          quoted     = 1'b0;
        end
        // a full hold releases the oldest carriage return as content
        if (held_crs >= CR_HOLD_LIMIT) line_byte(BYTE_CR);
        else held_crs++;
      end else begin
        while (held_crs > 0) begin
          line_byte(BYTE_CR);
          held_crs--;
        end
        line_byte(b);
      end
    end
    if (step_events > 0) begin
      r = field_events_q.pop_back();
      r.last = 1'b1;
      field_events_q.push_back(r);
    end
  endfunction

  task automatic check_field(input string what, input logic [8:0] want,
                             input logic [8:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      fail_count++;
    end
  endtask

  // compare result transfers, then track register writes and byte transfers
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      sep_byte   = SEP_RESET;
      header_en  = 1'b0;
      clear_stream();
      field_events_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (field_events_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind %0d data %0h",
                   $time, out_kind, out_data_byte);
          fail_count++;
        end else begin
          want = field_events_q.pop_front();
          check_field("kind", 9'(want.kind), 9'(out_kind));
          check_field("data_byte", 9'(want.data_byte), 9'(out_data_byte));
          check_field("field_index", 9'(want.field_index), 9'(out_field_index));
          check_field("is_header", 9'(want.is_header), 9'(out_is_header));
          check_field("widest_row", want.widest_row, out_widest_row);
          check_field("last", 9'(want.last), 9'(out_last));
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_SEPARATOR: sep_byte = cfg_data;
          CFG_HEADER:    header_en = cfg_data[0];
          default:       ;
        endcase
      end
      if (in_valid && !in_stall) predict_byte(in_byte, in_end_of_stream);
    end
    open_count = field_events_q.size();
  end

endmodule

/* tb/sv/tb_csv_line_field_splitter.sv */
// ----------------------------------------------------------------------------
// tb_csv_line_field_splitter
// Drives the csv splitter with a short directed byte sequence (quotes, doubled
// quotes, carriage return stripping, empty lines, end of stream) and then with
// random csv lines and noise under several separator and header settings,
// including long carriage return runs. Both channels idle at random. The
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_csv_line_field_splitter;
  import csvs_pkg::*;

  localparam int       PHASES       = 8;
  localparam int       PHASE_ITEMS  = 30;
  localparam int       SETTLE_CYC   = 10;
  localparam logic [8:0] EOS_ITEM   = 9'h100;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [7:0]            in_byte;
  logic                  in_end_of_stream;
  logic                  out_valid;
  logic                  out_stall;
  logic [1:0]            out_kind;
  logic [7:0]            out_data_byte;
  logic [7:0]            out_field_index;
  logic                  out_is_header;
  logic [8:0]            out_widest_row;
  logic                  out_last;

  int                    fail_count;
  int                    open_count;
  logic                  quiet;
  logic [7:0]            sep_now;
  int                    phase_bytes;

  // opening sequence: quotes, escapes, stripping, empty line, end of stream
  logic [8:0] opening_script [27] = '{
    9'h061, 9'h02C, {1'b0, BYTE_QT}, 9'h02C, {1'b0, BYTE_QT}, {1'b0, BYTE_QT},
    {1'b0, BYTE_QT}, 9'h062, {1'b0, BYTE_CR}, {1'b0, BYTE_NL}, {1'b0, BYTE_NL},
    9'h0FF, 9'h000, {1'b0, BYTE_CR}, {1'b0, BYTE_CR}, 9'h078, {1'b0, BYTE_QT},
    {1'b0, BYTE_QT}, {1'b0, BYTE_CR}, {1'b0, BYTE_NL}, {1'b0, BYTE_QT},
    {1'b0, BYTE_QT}, {1'b0, BYTE_NL}, 9'h071, {1'b0, BYTE_CR}, EOS_ITEM, EOS_ITEM
  };

  // separator and header flag per random phase
  logic [7:0] phase_sep [PHASES] = '{
    8'h2C, 8'h00, 8'hFF, BYTE_QT, BYTE_NL, BYTE_CR, 8'h3B, 8'h09
  };
  logic       phase_hdr [PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

  csv_line_field_splitter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .in_end_of_stream (in_end_of_stream),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_data_byte    (out_data_byte),
    .out_field_index  (out_field_index),
    .out_is_header    (out_is_header),
    .out_widest_row   (out_widest_row),
    .out_last         (out_last)
  );

  csv_splitter_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .in_end_of_stream (in_end_of_stream),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_data_byte    (out_data_byte),
    .out_field_index  (out_field_index),
    .out_is_header    (out_is_header),
    .out_widest_row   (out_widest_row),
    .out_last         (out_last),
    .fail_count       (fail_count),
    .open_count       (open_count)
  );

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // result side stalls at random
  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < 11);
  end

  // watchdog
  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

  // register write, entered and left at a falling edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // one byte transfer, entered and left at a falling edge
  task automatic send_item(input logic [7:0] b, input logic eos);
    while (!quiet && ($urandom_range(0, 99) < 11)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_byte          <= b;
    in_end_of_stream <= eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    phase_bytes++;
  endtask

  // any byte without a meaning of its own under the current separator
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b == BYTE_NL || b == BYTE_CR || b == BYTE_QT || b == sep_now);
    return b;
  endfunction

  // one csv line with random fields and a random line ending
  task automatic send_line();
    int nf;
    int nb;
    int pick;
    nf = $urandom_range(1, 5);
    for (int i = 0; i < nf; i++) begin
      if (i > 0) send_item(sep_now, 1'b0);
      if ($urandom_range(0, 99) < 30) begin
        // quoted field with separators, escapes and carriage returns inside
        send_item(BYTE_QT, 1'b0);
        nb = $urandom_range(0, 5);
        for (int j = 0; j < nb; j++) begin
          pick = $urandom_range(0, 9);
          if (pick == 0) begin
            send_item(BYTE_QT, 1'b0);
            send_item(BYTE_QT, 1'b0);
          end else if (pick == 1) begin
            send_item(sep_now, 1'b0);
          end else if (pick == 2) begin
            send_item(BYTE_CR, 1'b0);
          end else begin
            send_item(plain_byte(), 1'b0);
          end
        end
        send_item(BYTE_QT, 1'b0);
      end else begin
        nb = $urandom_range(0, 4);
        for (int j = 0; j < nb; j++) send_item(plain_byte(), 1'b0);
      end
    end
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      send_item(BYTE_NL, 1'b0);
    end else if (pick < 80) begin
      send_item(BYTE_CR, 1'b0);
      send_item(BYTE_NL, 1'b0);
    end else if (pick < 88) begin
      send_item(8'($urandom_range(0, 255)), 1'b1);
    end else if (pick < 95) begin
      // long carriage return run, which can overflow the hold
      nb = $urandom_range(13, 20);
      for (int j = 0; j < nb; j++) send_item(BYTE_CR, 1'b0);
      if ($urandom_range(0, 1) == 0) send_item(BYTE_NL, 1'b0);
      else send_item(plain_byte(), 1'b0);
    end
  endtask

  // a short burst of unstructured bytes
  task automatic send_noise();
    int n;
    int pick;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) send_item(BYTE_NL, 1'b0);
      else if (pick < 20) send_item(BYTE_CR, 1'b0);
      else if (pick < 30) send_item(BYTE_QT, 1'b0);
      else if (pick < 35) send_item(8'($urandom_range(0, 255)), 1'b1);
      else send_item(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  // wait until every predicted result has arrived and the block has settled
  task automatic drain();
    while (open_count != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_index        = CFG_SEPARATOR;
    cfg_data         = 8'd0;
    in_valid         = 1'b0;
    in_byte          = 8'd0;
    in_end_of_stream = 1'b0;
    out_stall        = 1'b0;
    quiet            = 1'b0;
    sep_now          = SEP_RESET;
    phase_bytes      = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part with header flag on
    write_reg(CFG_SEPARATOR, SEP_RESET);
    write_reg(CFG_HEADER, 8'd1);
    foreach (opening_script[i]) send_item(opening_script[i][7:0], opening_script[i][8]);
    in_valid <= 1'b0;
    drain();

    // random phases over separator and header settings
    for (int p = 0; p < PHASES; p++) begin
      sep_now = (p == 6) ? 8'($urandom_range(0, 255)) : phase_sep[p];
      write_reg(CFG_SEPARATOR, sep_now);
      write_reg(CFG_HEADER, {7'd0, phase_hdr[p]});
      quiet = (p == 2);
      phase_bytes = 0;
      send_item(8'($urandom_range(0, 255)), 1'b1);
      while (phase_bytes < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 80) send_line();
        else send_noise();
      end
      in_valid <= 1'b0;
      drain();
    end

    if (fail_count == 0 && open_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
